// ===== design/sacc_pkg.sv =====
// Shared types, constants and helpers for the set-associative cache tag controller.
`default_nettype none
package sacc_pkg;

    localparam int NUM_SETS = 256;
    localparam int NUM_WAYS = 8;
    localparam int SET_W    = 8;
    localparam int WAY_W    = 3;
    localparam int ADDR_W   = 32;
    localparam int TAG_W    = 32;
    localparam int RANK_W   = 3;
    localparam int CNT_W    = 12;
    localparam int COST_W   = 18;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 32;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    localparam logic [1:0] MODE_READ     = 2'd0;
    localparam logic [1:0] MODE_WRITE    = 2'd1;
    localparam logic [1:0] MODE_FLUSH    = 2'd2;
    localparam logic [1:0] MODE_READ_ALT = 2'd3;   // spare code, behaves as a read

    localparam logic [2:0] REG_WRITE_BACK  = 3'd0;
    localparam logic [2:0] REG_RANDOM      = 3'd1;
    localparam logic [2:0] REG_OFFSET_BITS = 3'd2;
    localparam logic [2:0] REG_INDEX_BITS  = 3'd3;
    localparam logic [2:0] REG_WAY_BITS    = 3'd4;
    localparam logic [2:0] REG_HIT_COST    = 3'd5;
    localparam logic [2:0] REG_MEM_COST    = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_FL_RD,
        ST_FL_WR,
        ST_FL_END
    } state_t;

    typedef struct packed {
        logic        write_back;
        logic        random_replace;
        logic [4:0]  offset_bits;
        logic [3:0]  index_bits;
        logic [1:0]  way_bits;
        logic [15:0] hit_cost;
        logic [15:0] memory_cost;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic rd_acc;
        logic rd_fl;
        logic commit_acc;
        logic commit_fl;
        logic walk_inc;
        logic out_flush;
    } cmd_t;

    typedef struct packed {
        logic in_flush;
        logic write_back;
        logic out_free;
        logic flush_last;
    } sts_t;

    typedef struct packed {
        logic [NUM_WAYS-1:0]             valid;
        logic [NUM_WAYS-1:0]             dirty;
        logic [NUM_WAYS-1:0][TAG_W-1:0]  tag;
        logic [NUM_WAYS-1:0][RANK_W-1:0] rank;
    } row_t;

    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        logic [15:0] r;
        r = v >> 1;
        if (v[0])
        begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/sacc_ctrl.sv =====
// Sequencer for accesses and the flush walk.
`default_nettype none
module sacc_ctrl
    import sacc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    cmd.rd_acc = 1'b1;
                    if (sts.in_flush)
                    begin
                        state_next = sts.write_back ? ST_FL_RD : ST_FL_END;
                    end
                    else
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit_acc = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FL_RD:
            begin
                cmd.rd_fl  = 1'b1;
                state_next = ST_FL_WR;
            end
            ST_FL_WR:
            begin
                cmd.commit_fl = 1'b1;
                if (sts.flush_last)
                begin
                    state_next = ST_FL_END;
                end
                else
                begin
                    cmd.walk_inc = 1'b1;
                    state_next   = ST_FL_RD;
                end
            end
            ST_FL_END:
            begin
                if (sts.out_free)
                begin
                    cmd.out_flush = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_acc |-> sts.out_free)
        else $error("access result loaded over a waiting result");
    a_flush_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_flush |-> sts.out_free)
        else $error("flush result loaded over a waiting result");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg != ST_IDLE))
        else $error("controller idle right after taking an item");
    a_walk_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_fl |=> cmd.commit_fl)
        else $error("flush read not followed by its write");

endmodule
`default_nettype wire

// ===== design/sacc_dp.sv =====
// Tag store, hit/victim logic, flush counter and result register.
`default_nettype none
module sacc_dp
    import sacc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic [IN_W-1:0]   in_data,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [OUT_W-1:0]       out_data
);

    row_t mem [NUM_SETS];
    logic [NUM_SETS-1:0] row_ok_reg;

    row_t              rd_q_reg;
    logic              rd_ok_reg;
    logic [SET_W-1:0]  set_q_reg;
    logic [1:0]        mode_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SET_W-1:0]  walk_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [15:0]       lfsr_reg;

    logic              out_valid_reg;
    logic              hit_reg, reads_reg;
    logic [CNT_W-1:0]  writes_reg;
    logic [COST_W-1:0] cost_reg;

    logic [3:0]        ib_sat;
    logic [SET_W-1:0]  set_mask, in_set, rd_set;
    logic [5:0]        tag_shift;
    logic [TAG_W-1:0]  tag_q;
    logic [3:0]        way_cnt;
    logic [NUM_WAYS-1:0] en;
    row_t              cur, acc_row, fl_row, new_row;
    logic              wr_en;

    logic              is_write, hit, alloc, found;
    logic [NUM_WAYS-1:0] hit_vec;
    logic [WAY_W-1:0]  hit_way, inv_way, lru_way, pos, tw;
    logic [RANK_W-1:0] best;
    logic [15:0]       lfsr_n;
    logic [3:0]        old_rank;
    logic              acc_writes;
    logic [1:0]        xfers;
    logic [COST_W-1:0] acc_cost;
    logic [3:0]        fl_cnt;

    // geometry
    always_comb
    begin
        ib_sat    = (cfg.index_bits > 4'(SET_W)) ? 4'(SET_W) : cfg.index_bits;
        set_mask  = SET_W'((9'd1 << ib_sat) - 9'd1);
        in_set    = SET_W'(in_data[33:2] >> cfg.offset_bits) & set_mask;
        rd_set    = cmd.rd_fl ? walk_reg : in_set;
        tag_shift = 6'(cfg.offset_bits) + 6'(ib_sat);
        tag_q     = addr_reg >> tag_shift;
        way_cnt   = 4'd1 << cfg.way_bits;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            en[i] = (4'(i) < way_cnt);
        end
        // rows never written read as reset: nothing valid, clean, rank zero
        cur = rd_q_reg;
        if (!rd_ok_reg)
        begin
            cur.valid = '0;
            cur.dirty = '0;
            cur.rank  = '0;
        end
    end

    // access: hit search, victim choice, recency update
    always_comb
    begin
        is_write = (mode_reg == MODE_WRITE);
        hit_way  = '0;
        inv_way  = '0;
        found    = 1'b0;
        lru_way  = '0;
        best     = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            hit_vec[i] = en[i] & cur.valid[i] & (cur.tag[i] == tag_q);
        end
        hit = |hit_vec;
        for (int i = NUM_WAYS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_way = WAY_W'(i);
            end
            if (en[i] && !cur.valid[i])
            begin
                inv_way = WAY_W'(i);
                found   = 1'b1;
            end
        end
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (en[i] && cur.rank[i] > best)
            begin
                best    = cur.rank[i];
                lru_way = WAY_W'(i);
            end
        end
        lfsr_n = lfsr_next(lfsr_reg);
        alloc  = !hit && !(is_write && !cfg.write_back);
        if (found)
        begin
            pos = inv_way;
        end
        else if (cfg.random_replace)
        begin
            pos = lfsr_n[WAY_W-1:0] & WAY_W'(way_cnt - 4'd1);
        end
        else
        begin
            pos = lru_way;
        end
        tw       = hit ? hit_way : pos;
        old_rank = cur.valid[tw] ? {1'b0, cur.rank[tw]} : way_cnt;

        acc_row = cur;
        if (hit || alloc)
        begin
            for (int i = 0; i < NUM_WAYS; i++)
            begin
                if (en[i] && WAY_W'(i) != tw && cur.valid[i]
                    && {1'b0, cur.rank[i]} < old_rank
                    && cur.rank[i] != RANK_W'(NUM_WAYS - 1))
                begin
                    acc_row.rank[i] = cur.rank[i] + RANK_W'(1);
                end
            end
            acc_row.rank[tw] = '0;
        end
        if (alloc)
        begin
            acc_row.valid[pos] = 1'b1;
            acc_row.tag[pos]   = tag_q;
            acc_row.dirty[pos] = is_write;
        end
        if (hit && is_write && cfg.write_back)
        begin
            acc_row.dirty[hit_way] = 1'b1;
        end

        acc_writes = (is_write && !cfg.write_back)
                   | (alloc && !found && cfg.write_back && cur.dirty[pos]);
        xfers = {1'b0, alloc} + {1'b0, acc_writes};
        unique case (xfers)
            2'd0:    acc_cost = COST_W'(cfg.hit_cost);
            2'd1:    acc_cost = COST_W'(cfg.hit_cost) + COST_W'(cfg.memory_cost);
            default: acc_cost = COST_W'(cfg.hit_cost) + COST_W'({cfg.memory_cost, 1'b0});
        endcase
    end

    // flush of one set: count and clear dirty valid lines in use
    always_comb
    begin
        fl_row = cur;
        fl_cnt = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (en[i] && cur.valid[i] && cur.dirty[i])
            begin
                fl_row.dirty[i] = 1'b0;
                fl_cnt          = fl_cnt + 4'd1;
            end
        end
        count_next = count_reg + CNT_W'(fl_cnt);
        new_row    = cmd.commit_acc ? acc_row : fl_row;
        wr_en      = cmd.commit_acc | cmd.commit_fl;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_acc || cmd.rd_fl)
        begin
            rd_q_reg  <= mem[rd_set];
            set_q_reg <= rd_set;
        end
        if (wr_en)
        begin
            mem[set_q_reg] <= new_row;
        end
        if (cmd.accept)
        begin
            mode_reg <= in_data[1:0];
            addr_reg <= in_data[33:2];
        end
        if (cmd.commit_acc || cmd.out_flush)
        begin
            hit_reg    <= cmd.commit_acc & hit;
            reads_reg  <= cmd.commit_acc & alloc;
            writes_reg <= cmd.commit_acc ? CNT_W'(acc_writes) : count_reg;
            cost_reg   <= cmd.commit_acc ? acc_cost : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg    <= '0;
            rd_ok_reg     <= 1'b0;
            walk_reg      <= '0;
            count_reg     <= '0;
            lfsr_reg      <= LFSR_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rd_acc || cmd.rd_fl)
            begin
                rd_ok_reg <= row_ok_reg[rd_set];
            end
            if (wr_en)
            begin
                row_ok_reg[set_q_reg] <= 1'b1;
            end
            if (cmd.accept)
            begin
                walk_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                if (cmd.walk_inc)
                begin
                    walk_reg <= walk_reg + SET_W'(1);
                end
                if (cmd.commit_fl)
                begin
                    count_reg <= count_next;
                end
            end
            if (cmd.commit_acc && alloc && !found && cfg.random_replace)
            begin
                lfsr_reg <= lfsr_n;
            end
            if (cmd.commit_acc || cmd.out_flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.in_flush   = (in_data[1:0] == MODE_FLUSH);
        sts.write_back = cfg.write_back;
        sts.out_free   = !out_valid_reg || out_ready;
        sts.flush_last = (walk_reg == set_mask);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {cost_reg, writes_reg, reads_reg, hit_reg};

    a_flush_no_cost: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_flush |=> (cost_reg == '0) && !hit_reg && !reads_reg)
        else $error("flush result carries access fields");
    a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != 16'd0)
        else $error("victim lfsr stuck at zero");
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_fl |-> ((walk_reg & ~set_mask) == '0))
        else $error("flush walk beyond sets in use");

endmodule
`default_nettype wire

// ===== design/set_assoc_cache_tag_controller_top.sv =====
// Set-associative cache tag controller (LRU/random, write-through/write-back): top level.
//
// s_* channel takes one request item: read, write or flush of dirty lines.
// m_* channel returns one result item per request, in order.
// cfg_* channel writes the seven configuration registers; cfg_ready is always
// high and writes are expected only while no request is in flight.
// For an access, the set row is read from the tag store in the accept cycle and
// the updated row is written back as the result is loaded. A new request is
// taken the cycle after the result is loaded.
// A flush in write-back mode walks the sets in use, with one store read and one
// store write per set; in write-through mode it skips the walk and only loads
// its result.
// Reset clears the configuration to its defaults, all per-set row-written
// flags (so every line reads invalid, clean, rank zero) and seeds the LFSR;
// no clearing pass is needed.
// If the receiver stalls, the result waits in the output register; one more
// request may be accepted and read (a flush also walks its sets), then the block
// holds it until the output register frees up.
`default_nettype none
module set_assoc_cache_tag_controller_top
    import sacc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,   // mode[1:0], address[33:2], zero[39:34]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,   // hit[0], memory_reads[1],
                                              // memory_writes[13:2], access_cost[31:14]
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.write_back     <= 1'b0;
            cfg_reg.random_replace <= 1'b0;
            cfg_reg.offset_bits    <= '0;
            cfg_reg.index_bits     <= '0;
            cfg_reg.way_bits       <= '0;
            cfg_reg.hit_cost       <= 16'd1;
            cfg_reg.memory_cost    <= 16'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WRITE_BACK:  cfg_reg.write_back     <= cfg_data[0];
                REG_RANDOM:      cfg_reg.random_replace <= cfg_data[0];
                REG_OFFSET_BITS: cfg_reg.offset_bits    <= cfg_data[4:0];
                REG_INDEX_BITS:  cfg_reg.index_bits     <= cfg_data[3:0];
                REG_WAY_BITS:    cfg_reg.way_bits       <= cfg_data[1:0];
                REG_HIT_COST:    cfg_reg.hit_cost       <= cfg_data;
                REG_MEM_COST:    cfg_reg.memory_cost    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    sacc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sacc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
`default_nettype wire
